@@ design/ray_unit_sphere_intersect_defines.svh @@
// Assertion macros shared by the ray against unit sphere design.
`ifndef RAY_UNIT_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_UNIT_SPHERE_INTERSECT_DEFINES_SVH

// Same-cycle implication.
`define RUSI_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RUSI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rusi_pkg.sv @@
// Shared constants and helpers for the ray against unit sphere design.
package rusi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;
  localparam int NW = 18;
  localparam int HW = 36;
  localparam int TW = 36;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  function automatic logic [CW-1:0] mag32(input logic [CW-1:0] x);
    return x[CW-1] ? (~x + 32'd1) : x;
  endfunction

endpackage

@@ design/rusi_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
`include "ray_unit_sphere_intersect_defines.svh"

module rusi_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  `RUSI_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= (AW+1)'(DEPTH), "queue count above depth")
  `RUSI_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "queue count did not grow")

endmodule

@@ design/rusi_sqrt.sv @@
// Pipelined floor square root, one result bit per stage, with a side payload.
module rusi_sqrt #(
  parameter int W = 64,
  parameter int PW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   x,
  input  logic [PW-1:0]  in_pl,
  output logic           out_valid,
  output logic [W/2-1:0] root,
  output logic [PW-1:0]  out_pl
);

  localparam int R = W / 2;

  logic          vld_q  [R];
  logic [R+1:0]  rem_q  [R];
  logic [R-1:0]  root_q [R];
  logic [W-1:0]  x_q    [R];
  logic [PW-1:0] pl_q   [R];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic          v_p;
    logic [R+1:0]  rem_p;
    logic [R-1:0]  root_p;
    logic [W-1:0]  x_p;
    logic [PW-1:0] pl_p;
    logic [R+3:0]  rem_sh;
    logic [R+3:0]  trial;
    logic [R+3:0]  diff;
    logic          take;

    if (k == 0) begin : g_head
      assign v_p = in_valid;
      assign rem_p = '0;
      assign root_p = '0;
      assign x_p = x;
      assign pl_p = in_pl;
    end else begin : g_body
      assign v_p = vld_q[k-1];
      assign rem_p = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign x_p = x_q[k-1];
      assign pl_p = pl_q[k-1];
    end

    assign rem_sh = {rem_p, x_p[W-1:W-2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign take = (rem_sh >= trial);
    assign diff = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_p;
      end
      if (en) begin
        rem_q[k] <= take ? diff[R+1:0] : rem_sh[R+1:0];
        root_q[k] <= {root_p[R-2:0], take};
        x_q[k] <= {x_p[W-3:0], 2'b00};
        pl_q[k] <= pl_p;
      end
    end
  end

  assign out_valid = vld_q[R-1];
  assign root = root_q[R-1];
  assign out_pl = pl_q[R-1];

endmodule

@@ design/rusi_div.sv @@
// Pipelined three-lane divider sharing one divisor, one quotient bit per stage.
module rusi_div #(
  parameter int QW = 17,
  parameter int PW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][31:0]     num,
  input  logic [31:0]          den,
  input  logic [PW-1:0]        in_pl,
  output logic                 out_valid,
  output logic [2:0][QW-1:0]   quo,
  output logic [PW-1:0]        out_pl
);

  logic                 vld_q [QW];
  logic [31:0]          den_q [QW];
  logic [PW-1:0]        pl_q  [QW];
  logic [2:0][32:0]     r_q   [QW];
  logic [2:0][QW-1:0]   q_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               v_p;
    logic [31:0]        den_p;
    logic [PW-1:0]      pl_p;
    logic [2:0][32:0]   r_p;
    logic [2:0][QW-1:0] q_p;
    logic [2:0][32:0]   r_n;
    logic [2:0][QW-1:0] q_n;

    if (k == 0) begin : g_head
      assign v_p = in_valid;
      assign den_p = den;
      assign pl_p = in_pl;
      assign q_p = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign r_p[l] = {1'b0, num[l]};
      end
    end else begin : g_body
      assign v_p = vld_q[k-1];
      assign den_p = den_q[k-1];
      assign pl_p = pl_q[k-1];
      assign r_p = r_q[k-1];
      assign q_p = q_q[k-1];
    end

    always_comb begin
      logic        ge;
      logic [32:0] diff;
      logic [32:0] rd;
      for (int l = 0; l < 3; l++) begin
        ge = (r_p[l] >= {1'b0, den_p});
        diff = r_p[l] - {1'b0, den_p};
        rd = ge ? diff : r_p[l];
        r_n[l] = {rd[31:0], 1'b0};
        q_n[l] = {q_p[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_p;
      end
      if (en) begin
        den_q[k] <= den_p;
        pl_q[k] <= pl_p;
        r_q[k] <= r_n;
        q_q[k] <= q_n;
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quo = q_q[QW-1];
  assign out_pl = pl_q[QW-1];

endmodule

@@ design/rusi_front.sv @@
// Front pipeline: takes rays, normalizes the direction and forms the projection h.
module rusi_front import rusi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 2,
  localparam int MID_W = 3*CW + 3*VW + HW + 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              ready,
  input  logic [2:0][CW-1:0] o_in,
  input  logic [2:0][CW-1:0] d_in,
  output logic              item_valid,
  input  logic              item_ready,
  output logic [MID_W-1:0]  item
);

  localparam int QW = FRAC_BITS + 1;
  localparam int SPW = 6*CW + 64;
  localparam int DPW = 3*CW + 3 + 64 + 1;
  localparam int PRW = CW + VW;
  localparam int AW = CW + VW + 2;

  logic en;

  logic v0, v1, v2, v4, v5, v6;
  logic [2:0][CW-1:0] o0, d0, o1, d1, o2, d2, o4, o5;
  logic [2:0][63:0] dsq1, osq1;
  logic [63:0] dsum2, osum2, osum4, osum5, osum6;
  logic [2:0][VW-1:0] vv4, vv5, vv6;
  logic [2:0][PRW-1:0] prod5;
  logic [2:0][CW-1:0] o6;
  logic [HW-1:0] h6;

  logic sv;
  logic [CW-1:0] m;
  logic [SPW-1:0] spl;
  logic [2:0][CW-1:0] o3, d3;
  logic [63:0] osum3;
  logic [2:0][CW-1:0] dmag3;

  logic dv;
  logic [2:0][QW-1:0] q;
  logic [DPW-1:0] dpl;

  logic signed [AW-1:0] acc;
  logic [AW-1:0] acc_mag;
  logic [AW-1:0] acc_sh;
  logic [AW-1:0] h_full;
  logic [HW-1:0] h_next;

  assign en = !(v6 && !item_ready);
  assign ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v0 <= push;
      v1 <= v0;
      v2 <= v1;
      v4 <= dv;
      v5 <= v4;
      v6 <= v5;
    end
    if (en) begin
      o0 <= o_in;
      d0 <= d_in;
      o1 <= o0;
      d1 <= d0;
      for (int i = 0; i < 3; i++) begin
        dsq1[i] <= mag32(d0[i]) * mag32(d0[i]);
        osq1[i] <= mag32(o0[i]) * mag32(o0[i]);
      end
      o2 <= o1;
      d2 <= d1;
      dsum2 <= dsq1[0] + dsq1[1] + dsq1[2];
      osum2 <= osq1[0] + osq1[1] + osq1[2];
      o4 <= dpl[DPW-1 -: 3*CW];
      osum4 <= dpl[64:1];
      for (int i = 0; i < 3; i++) begin
        if (!dpl[0]) begin
          vv4[i] <= '0;
        end else if (dpl[65+i]) begin
          vv4[i] <= -{1'b0, q[i]};
        end else begin
          vv4[i] <= {1'b0, q[i]};
        end
      end
      o5 <= o4;
      vv5 <= vv4;
      osum5 <= osum4;
      for (int i = 0; i < 3; i++) begin
        prod5[i] <= $signed({{VW{o4[i][CW-1]}}, o4[i]}) *
                    $signed({{CW{vv4[i][VW-1]}}, vv4[i]});
      end
      o6 <= o5;
      vv6 <= vv5;
      osum6 <= osum5;
      h6 <= h_next;
    end
  end

  always_comb begin
    acc = $signed({{2{prod5[0][PRW-1]}}, prod5[0]}) +
          $signed({{2{prod5[1][PRW-1]}}, prod5[1]}) +
          $signed({{2{prod5[2][PRW-1]}}, prod5[2]});
    acc_mag = acc[AW-1] ? -acc : acc;
    acc_sh = acc_mag >> FRAC_BITS;
    h_full = acc[AW-1] ? -acc_sh : acc_sh;
    h_next = h_full[HW-1:0];
  end

  rusi_sqrt #(.W(64), .PW(SPW)) u_dir_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .x(dsum2), .in_pl({o2, d2, osum2}),
    .out_valid(sv), .root(m), .out_pl(spl)
  );

  assign o3 = spl[SPW-1 -: 3*CW];
  assign d3 = spl[64 +: 3*CW];
  assign osum3 = spl[63:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag3[i] = mag32(d3[i]);
    end
  end

  rusi_div #(.QW(QW), .PW(DPW)) u_dir_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sv), .num(dmag3), .den(m),
    .in_pl({o3, d3[2][CW-1], d3[1][CW-1], d3[0][CW-1], osum3, (m != '0)}),
    .out_valid(dv), .quo(q), .out_pl(dpl)
  );

  assign item_valid = v6;
  assign item = {o6, vv6, h6, osum6};

endmodule

@@ design/rusi_back.sv @@
// Back pipeline: discriminant, nearer root, hit point and its unit normal.
module rusi_back import rusi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VW = FRAC_BITS + 2,
  localparam int MID_W = 3*CW + 3*VW + HW + 64,
  localparam int RES_W = 1 + 3*CW + 3*NW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_avail,
  output logic             item_pop,
  input  logic [MID_W-1:0] item,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [RES_W-1:0] res
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = 2*FRAC_BITS + 2;
  localparam int SPW = 3*CW + 3*VW + 34 + 1;
  localparam int PRW = VW + TW;
  localparam int NPW = 3*CW + 1;
  localparam int DPW = 3*CW + 2;
  localparam logic [68:0] ONE2 = 69'd1 << (2*FRAC_BITS);
  localparam logic signed [PRW:0] PMAX = {{(PRW+2-CW){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [PRW:0] PMIN = {{(PRW+2-CW){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [33:0] NMAX = 34'sd131071;
  localparam logic signed [33:0] NMIN = -34'sd131072;

  logic en;
  logic v0, v1, v2, v3, v4, v5, v6, v7;

  logic [2:0][CW-1:0] oi;
  logic [2:0][VW-1:0] vi;
  logic [HW-1:0] hi;
  logic [63:0] osumi;
  logic [HW-1:0] hi_mag;

  logic [2:0][CW-1:0] o0, o1, o2, o3;
  logic [2:0][VW-1:0] vv0, vv1, vv2;
  logic hneg0;
  logic [33:0] hmag0, hmag1;
  logic [63:0] osum0;
  logic [67:0] h2_0;
  logic ok1, ok2, ok3, ok4, ok5, ok6;
  logic [DW-1:0] disc1;
  logic [TW-1:0] t2;
  logic [2:0][PRW-1:0] prod3;
  logic [2:0][CW-1:0] p4, p5, p6, p7;
  logic [2:0][63:0] psq5;
  logic [63:0] psum6;
  logic hit7;
  logic [2:0][NW-1:0] n7;

  logic [68:0] sum_b1;
  logic [68:0] diff_b1;
  logic [68:0] osum_ext;

  logic sv;
  logic [FRAC_BITS:0] s;
  logic [SPW-1:0] spl;
  logic [2:0][CW-1:0] os;
  logic [2:0][VW-1:0] vs;
  logic [33:0] hs;

  logic [2:0][CW-1:0] p4_next;

  logic nsv;
  logic [CW-1:0] pm;
  logic [NPW-1:0] npl;
  logic [2:0][CW-1:0] pn;
  logic [2:0][CW-1:0] pn_mag;

  logic dv;
  logic [2:0][QW-1:0] q;
  logic [DPW-1:0] dpl;
  logic [2:0][CW-1:0] pd;
  logic [2:0][NW-1:0] n_next;

  assign en = !(v7 && !res_ready);
  assign item_pop = en && item_avail;

  assign {oi, vi, hi, osumi} = item;
  assign hi_mag = hi[HW-1] ? -hi : hi;

  assign osum_ext = {5'b0, osum0};
  assign sum_b1 = {1'b0, h2_0} + ONE2;
  assign diff_b1 = sum_b1 - osum_ext;

  assign os = spl[SPW-1 -: 3*CW];
  assign vs = spl[35 +: 3*VW];
  assign hs = spl[34:1];

  always_comb begin
    logic [PRW-1:0] pmag;
    logic [PRW-1:0] psh;
    logic [PRW-1:0] ptr;
    logic signed [PRW:0] psum;
    for (int i = 0; i < 3; i++) begin
      pmag = prod3[i][PRW-1] ? -prod3[i] : prod3[i];
      psh = pmag >> FRAC_BITS;
      ptr = prod3[i][PRW-1] ? -psh : psh;
      psum = $signed({{(PRW+1-CW){o3[i][CW-1]}}, o3[i]}) + $signed({ptr[PRW-1], ptr});
      if (!ok3) begin
        p4_next[i] = '0;
      end else if (psum > PMAX) begin
        p4_next[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (psum < PMIN) begin
        p4_next[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        p4_next[i] = psum[CW-1:0];
      end
    end
  end

  assign pn = npl[NPW-1:1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pn_mag[i] = mag32(pn[i]);
    end
  end

  assign pd = dpl[DPW-1:2];
  always_comb begin
    logic signed [33:0] qe;
    logic signed [33:0] nv;
    for (int i = 0; i < 3; i++) begin
      qe = {{(34-QW){1'b0}}, q[i]};
      nv = pd[i][CW-1] ? -qe : qe;
      if (!dpl[0]) begin
        n_next[i] = '0;
      end else if (nv > NMAX) begin
        n_next[i] = NMAX[NW-1:0];
      end else if (nv < NMIN) begin
        n_next[i] = NMIN[NW-1:0];
      end else begin
        n_next[i] = nv[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v0 <= item_avail;
      v1 <= v0;
      v2 <= sv;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= dv;
    end
    if (en) begin
      o0 <= oi;
      vv0 <= vi;
      hneg0 <= hi[HW-1];
      hmag0 <= hi_mag[33:0];
      osum0 <= osumi;
      h2_0 <= hi_mag[33:0] * hi_mag[33:0];
      o1 <= o0;
      vv1 <= vv0;
      hmag1 <= hmag0;
      ok1 <= (osum_ext >= ONE2) && hneg0 && (sum_b1 > osum_ext);
      disc1 <= diff_b1[DW-1:0];
      o2 <= os;
      vv2 <= vs;
      ok2 <= spl[0];
      t2 <= {2'b00, hs} - {{(TW-QW){1'b0}}, s};
      o3 <= o2;
      ok3 <= ok2;
      for (int i = 0; i < 3; i++) begin
        prod3[i] <= $signed({{TW{vv2[i][VW-1]}}, vv2[i]}) *
                    $signed({{VW{t2[TW-1]}}, t2});
      end
      p4 <= p4_next;
      ok4 <= ok3;
      p5 <= p4;
      ok5 <= ok4;
      for (int i = 0; i < 3; i++) begin
        psq5[i] <= mag32(p4[i]) * mag32(p4[i]);
      end
      p6 <= p5;
      ok6 <= ok5;
      psum6 <= psq5[0] + psq5[1] + psq5[2];
      hit7 <= dpl[1];
      p7 <= pd;
      n7 <= n_next;
    end
  end

  rusi_sqrt #(.W(DW), .PW(SPW)) u_disc_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .x(disc1), .in_pl({o1, vv1, hmag1, ok1}),
    .out_valid(sv), .root(s), .out_pl(spl)
  );

  rusi_sqrt #(.W(64), .PW(NPW)) u_pt_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v6), .x(psum6), .in_pl({p6, ok6}),
    .out_valid(nsv), .root(pm), .out_pl(npl)
  );

  rusi_div #(.QW(QW), .PW(DPW)) u_pt_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(nsv), .num(pn_mag), .den(pm),
    .in_pl({pn, npl[0], (pm != '0)}),
    .out_valid(dv), .quo(q), .out_pl(dpl)
  );

  assign res_valid = v7;
  assign res = {hit7, p7, n7};

endmodule

@@ design/ray_unit_sphere_intersect.sv @@
// Top level of the ray against unit sphere intersection block.
//
//   Channel  Handshake     Fields
//   rays     push / full   origin_x/y/z, dir_x/y/z
//   results  pop / empty   hit, point_x/y/z, normal_x/y/z
//
// One ray is accepted per clock while full is low; each ray yields one result.
// On the way from accept to result a ray passes two 32-stage square roots, the
// discriminant root and two dividers of FRAC_BITS + 1 stages each, plus the
// register stages and the two queues.
// Front and back pipelines stall independently, decoupled by a four-entry queue.
// Reset is synchronous and empties both queues and all pipeline stages.
`include "ray_unit_sphere_intersect_defines.svh"

module ray_unit_sphere_intersect import rusi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [CW-1:0] origin_x,
  input  logic signed [CW-1:0] origin_y,
  input  logic signed [CW-1:0] origin_z,
  input  logic signed [CW-1:0] dir_x,
  input  logic signed [CW-1:0] dir_y,
  input  logic signed [CW-1:0] dir_z,
  input  logic                 pop,
  output logic                 empty,
  output logic                 hit,
  output logic signed [CW-1:0] point_x,
  output logic signed [CW-1:0] point_y,
  output logic signed [CW-1:0] point_z,
  output logic signed [NW-1:0] normal_x,
  output logic signed [NW-1:0] normal_y,
  output logic signed [NW-1:0] normal_z
);

  localparam int VW = FRAC_BITS + 2;
  localparam int MID_W = 3*CW + 3*VW + HW + 64;
  localparam int RES_W = 1 + 3*CW + 3*NW;

  logic front_ready;
  logic mid_valid;
  logic [MID_W-1:0] mid_item;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  logic [MID_W-1:0] mid_head;
  logic res_valid;
  logic [RES_W-1:0] res_item;
  logic out_full;
  logic [RES_W-1:0] out_head;

  assign full = !front_ready;

  rusi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst),
    .push(push), .ready(front_ready),
    .o_in({origin_z, origin_y, origin_x}),
    .d_in({dir_z, dir_y, dir_x}),
    .item_valid(mid_valid), .item_ready(!mid_full), .item(mid_item)
  );

  rusi_fifo #(.W(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst),
    .push(mid_valid), .wdata(mid_item), .full(mid_full),
    .pop(mid_pop), .rdata(mid_head), .empty(mid_empty)
  );

  rusi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .item_avail(!mid_empty), .item_pop(mid_pop), .item(mid_head),
    .res_valid(res_valid), .res_ready(!out_full), .res(res_item)
  );

  rusi_fifo #(.W(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst(rst),
    .push(res_valid), .wdata(res_item), .full(out_full),
    .pop(pop), .rdata(out_head), .empty(empty)
  );

  assign hit = out_head[RES_W-1];
  assign point_x = out_head[3*NW +: CW];
  assign point_y = out_head[3*NW + CW +: CW];
  assign point_z = out_head[3*NW + 2*CW +: CW];
  assign normal_x = out_head[0 +: NW];
  assign normal_y = out_head[NW +: NW];
  assign normal_z = out_head[2*NW +: NW];

  `RUSI_ASSERT_IMPLY(a_miss_zero, clk, rst, !empty && !hit, point_x == 0 && point_y == 0 && point_z == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0, "miss item carries nonzero fields")

endmodule

@@ dv/tb_ray_unit_sphere_intersect.sv @@
// Self-checking testbench for the ray against unit sphere intersection block.
`timescale 1ns / 100ps

module tb_ray_unit_sphere_intersect;
  import rusi_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 <<< F;

  typedef struct packed {
    logic hit;
    logic signed [CW-1:0] px, py, pz;
    logic signed [NW-1:0] nx, ny, nz;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic hit;
  logic signed [CW-1:0] point_x, point_y, point_z;
  logic signed [NW-1:0] normal_x, normal_y, normal_z;

  hit_rec_t pending_hits[$];
  int errors = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  ray_unit_sphere_intersect dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint trunc_frac(longint x);
    longint unsigned m;
    m = absval(x) >> F;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic bit unit_vec(input longint u[3], output longint r[3]);
    longint unsigned m, q;
    m = root64(absval(u[0]) * absval(u[0]) + absval(u[1]) * absval(u[1])
               + absval(u[2]) * absval(u[2]));
    for (int i = 0; i < 3; i++) r[i] = 0;
    if (m == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = (absval(u[i]) << F) / m;
      r[i] = u[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic hit_rec_t sphere_hit(input longint o[3], input longint d[3]);
    longint v[3], p[3], n[3], acc, h, t;
    longint unsigned o2, h2, one2, s;
    hit_rec_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      p[i] = 0;
      n[i] = 0;
    end
    if (unit_vec(d, v)) begin
      acc = o[0] * v[0] + o[1] * v[1] + o[2] * v[2];
      h = trunc_frac(acc);
      o2 = absval(o[0]) * absval(o[0]) + absval(o[1]) * absval(o[1])
           + absval(o[2]) * absval(o[2]);
      h2 = absval(h) * absval(h);
      one2 = 64'd1 << (2 * F);
      if (o2 >= one2 && h < 0 && h2 + one2 > o2) begin
        s = root64(h2 + one2 - o2);
        t = longint'(absval(h) - s);
        for (int i = 0; i < 3; i++)
          p[i] = clamp(o[i] + trunc_frac(v[i] * t), -64'sh80000000, 64'sh7FFFFFFF);
        if (unit_vec(p, n))
          for (int i = 0; i < 3; i++) n[i] = clamp(n[i], -64'sh20000, 64'sh1FFFF);
        r.hit = 1'b1;
      end
    end
    r.px = CW'(p[0]); r.py = CW'(p[1]); r.pz = CW'(p[2]);
    r.nx = NW'(n[0]); r.ny = NW'(n[1]); r.nz = NW'(n[2]);
    return r;
  endfunction

  task automatic send_ray(longint ox, longint oy, longint oz,
                          longint dx, longint dy, longint dz);
    longint o[3], d[3];
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    origin_x <= CW'(ox); origin_y <= CW'(oy); origin_z <= CW'(oz);
    dir_x <= CW'(dx); dir_y <= CW'(dy); dir_z <= CW'(dz);
    o[0] = longint'(CW'(ox)) <<< 32 >>> 32;
    o[1] = longint'(CW'(oy)) <<< 32 >>> 32;
    o[2] = longint'(CW'(oz)) <<< 32 >>> 32;
    d[0] = longint'(CW'(dx)) <<< 32 >>> 32;
    d[1] = longint'(CW'(dy)) <<< 32 >>> 32;
    d[2] = longint'(CW'(dz)) <<< 32 >>> 32;
    do @(posedge clk); while (full);
    pending_hits.push_back(sphere_hit(o, d));
  endtask

  always @(posedge clk) begin
    hit_rec_t exp_r, got;
    if (!rst && pop && !empty) begin
      got = {hit, point_x, point_y, point_z, normal_x, normal_y, normal_z};
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_hits.pop_front();
        if (got.hit !== exp_r.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, exp_r.hit, got.hit); errors++;
        end
        if (got.px !== exp_r.px) begin
          $display("%0t: point_x exp %0d got %0d", $time, exp_r.px, got.px); errors++;
        end
        if (got.py !== exp_r.py) begin
          $display("%0t: point_y exp %0d got %0d", $time, exp_r.py, got.py); errors++;
        end
        if (got.pz !== exp_r.pz) begin
          $display("%0t: point_z exp %0d got %0d", $time, exp_r.pz, got.pz); errors++;
        end
        if (got.nx !== exp_r.nx) begin
          $display("%0t: normal_x exp %0d got %0d", $time, exp_r.nx, got.nx); errors++;
        end
        if (got.ny !== exp_r.ny) begin
          $display("%0t: normal_y exp %0d got %0d", $time, exp_r.ny, got.ny); errors++;
        end
        if (got.nz !== exp_r.nz) begin
          $display("%0t: normal_z exp %0d got %0d", $time, exp_r.nz, got.nz); errors++;
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  function automatic longint rnd32();
    return longint'(int'($urandom()));
  endfunction

  function automatic longint near_val();
    return longint'($urandom_range(int'(6 * ONE))) - 3 * ONE;
  endfunction

  task automatic test_directed();
    send_ray(0, 0, -2 * ONE, 0, 0, ONE);
    send_ray(0, 0, -2 * ONE, 0, 0, -ONE);
    send_ray(0, 0, 0, ONE, 0, 0);
    send_ray(0, 0, -2 * ONE, 0, 0, 0);
    send_ray(0, ONE, -2 * ONE, 0, 0, ONE);
    send_ray(0, 2 * ONE, -2 * ONE, 0, 0, ONE);
    send_ray(ONE, 0, 0, -ONE, 0, 0);
    send_ray(ONE, 0, 0, ONE, 0, 0);
    send_ray(-3 * ONE, ONE / 2, ONE / 4, 5 * ONE, -7, 3);
    send_ray(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647, 2147483647);
    send_ray(2147483647, 2147483647, 2147483647, -2147483648, -2147483648, -2147483648);
    send_ray(-2147483648, 0, 0, 2147483647, 0, 0);
    send_ray(2147483647, 0, 0, -1, 0, 0);
    send_ray(0, -2147483648, 0, 0, 1, 0);
    send_ray(0, 0, 2147483647, 0, 0, -2147483648);
    send_ray(-1, -1, -1, -1, -1, -1);
    send_ray(32'hFFFFFFFF, 32'h5555AAAA, 32'hAAAA5555, 32'h7FFF0001, 32'h8000FFFF, 1);
  endtask

  task automatic test_random(int n);
    longint o[3], d[3], t;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: begin
          for (int i = 0; i < 6; i++) if (i < 3) o[i] = rnd32(); else d[i - 3] = rnd32();
        end
        1: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = rnd32() >>> $urandom_range(31);
            d[i] = rnd32() >>> $urandom_range(31);
          end
        end
        default: begin
          // Aim the ray toward a point near the sphere.
          t = 2 + $urandom_range(20);
          for (int i = 0; i < 3; i++) begin
            o[i] = near_val() * t / 3;
            d[i] = (longint'($urandom_range(int'(2 * ONE))) - ONE) * 3 / 4 - o[i];
          end
        end
      endcase
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_phase(int idle, int stall, int n);
    send_idle_pct = idle;
    pop_stall_pct = stall;
    test_random(n);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_phase(0, 0, 400);
    test_phase(81, 0, 300);
    test_phase(0, 81, 300);
    test_phase(27, 27, 300);
    if (errors == 0) begin
      $display("tb_ray_unit_sphere_intersect: done, clean");
    end else begin
      $display("tb_ray_unit_sphere_intersect: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_ray_unit_sphere_intersect: done, errors");
    $finish;
  end

endmodule
